### rtl/core/css_pkg.sv
// css_pkg: shared types and constants of the cursor sequence store
// used by css_ctrl, css_dp and cursor_sequence_store; no dependencies
package css_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 32;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;
  localparam int unsigned KIND_W              = 3;
  localparam int unsigned PORT_VALUE_W        = 32;

  // request codes
  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 3'd0,
    KIND_ADVANCE = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_ATTACH  = 3'd3,
    KIND_REMOVE  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_RD,
    ST_UP_WR,
    ST_PUT,
    ST_DN_CHK,
    ST_DN_RD,
    ST_DN_WR,
    ST_REM_END,
    ST_SETTLE,
    ST_FETCH,
    ST_LOAD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ZERO,
    CUR_INC,
    CUR_COUNT
  } cursor_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_CURSOR,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_CURSOR
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_VALUE
  } wr_sel_e;

  typedef struct packed {
    logic       accept;
    logic       set_err;
    cursor_op_e cur_op;
    idx_op_e    idx_op;
    rd_sel_e    rd_sel;
    wr_sel_e    wr_sel;
    logic       count_inc;
    logic       count_dec;
    logic       load_value;
    logic       load_cur;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has;
    logic full;
    logic idx_eq_cursor;
    logic idx_p1_lt_count;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/cursor_sequence_store.sv
// cursor_sequence_store: an ordered list of up to DEPTH values with a cursor
// one request at a time, each answered by exactly one result; the request
// sequencer (css_ctrl) and the entry datapath (css_dp, css_ram) sit below.
// A request is taken only while the block is idle; in_stall_o is high while a
// request is being worked. Entries live in a ram with one write port, one read
// port and a registered read, so an insert or remove moves the following
// entries one at a time, each by a check, a read and then a write. Start and
// advance reload the current entry from the ram when the cursor ends on one;
// insert and attach move the entries from the cursor position on up by one
// before the new value is written; remove moves the entries after the cursor
// down by one and then reloads the current entry. An advance or remove with no
// current entry, an unused code and a refused insert or attach go straight to
// the result. A result sits in an output register: the next request is taken
// while it waits, and the block holds before its following result until the
// output is free. No clearing pass is needed after reset: only entries below
// the count are ever read, and all of them were written.
module cursor_sequence_store #(
  parameter int unsigned DEPTH       = css_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = css_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [css_pkg::KIND_W-1:0]       kind_i,
  input  logic [css_pkg::PORT_VALUE_W-1:0] entry_value_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [css_pkg::PORT_VALUE_W-1:0] current_value_o,
  output logic                             has_current_o,
  output logic [$clog2(DEPTH+1)-1:0]       entry_count_o,
  output logic                             full_error_o
);
  import css_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: decodes the request and steps the shift sweeps
  css_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: count, cursor, sweep index, entry ram and output register
  css_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .entry_value_i   (entry_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_value_o (current_value_o),
    .has_current_o   (has_current_o),
    .entry_count_o   (entry_count_o),
    .full_error_o    (full_error_o)
  );

endmodule

### rtl/core/css_ram.sv
// css_ram: generic single write port, single read port ram with registered read
// no dependencies
module css_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/css_ctrl.sv
// css_ctrl: request sequencer of the cursor sequence store
// depends on css_pkg; drives css_dp through ctrl_cmd_t
module css_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [css_pkg::KIND_W-1:0] kind_i,
  input  css_pkg::dp_status_t    status_i,
  output css_pkg::ctrl_cmd_t     cmd_o
);
  import css_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (kind_i) inside
            KIND_START: begin
              cmd_o.cur_op = CUR_ZERO;
              state_d      = ST_SETTLE;
            end
            KIND_ADVANCE: begin
              if (status_i.has) begin
                cmd_o.cur_op = CUR_INC;
                state_d      = ST_SETTLE;
              end else begin
                state_d = ST_DONE;
              end
            end
            KIND_INSERT, KIND_ATTACH: begin
              if (status_i.full) begin
                cmd_o.set_err = 1'b1;
                state_d       = ST_DONE;
              end else begin
                if (kind_i == KIND_INSERT) begin
                  cmd_o.cur_op = status_i.has ? CUR_HOLD : CUR_ZERO;
                end else begin
                  cmd_o.cur_op = status_i.has ? CUR_INC : CUR_COUNT;
                end
                cmd_o.idx_op = IDX_COUNT;
                state_d      = ST_UP_CHK;
              end
            end
            KIND_REMOVE: begin
              if (status_i.has) begin
                cmd_o.idx_op = IDX_CURSOR;
                state_d      = ST_DN_CHK;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_UP_CHK: begin
        state_d = status_i.idx_eq_cursor ? ST_PUT : ST_UP_RD;
      end
      ST_UP_RD: begin
        cmd_o.rd_sel = RD_IDX_M1;
        state_d      = ST_UP_WR;
      end
      ST_UP_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        state_d      = ST_UP_CHK;
      end
      ST_PUT: begin
        cmd_o.wr_sel     = WR_VALUE;
        cmd_o.load_value = 1'b1;
        cmd_o.count_inc  = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DN_CHK: begin
        state_d = status_i.idx_p1_lt_count ? ST_DN_RD : ST_REM_END;
      end
      ST_DN_RD: begin
        cmd_o.rd_sel = RD_IDX_P1;
        state_d      = ST_DN_WR;
      end
      ST_DN_WR: begin
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
        state_d      = ST_DN_CHK;
      end
      ST_REM_END: begin
        cmd_o.count_dec = 1'b1;
        state_d         = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_d = status_i.has ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: begin
        cmd_o.rd_sel = RD_CURSOR;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_cur = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/css_dp.sv
// css_dp: datapath of the cursor sequence store (count, cursor, sweep index,
// entry ram, output register); depends on css_pkg and css_ram
module css_dp #(
  parameter int unsigned DEPTH       = css_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = css_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  css_pkg::ctrl_cmd_t                cmd_i,
  output css_pkg::dp_status_t               status_o,
  input  logic [css_pkg::PORT_VALUE_W-1:0]  entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [css_pkg::PORT_VALUE_W-1:0]  current_value_o,
  output logic                              has_current_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o,
  output logic                              full_error_o
);
  import css_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = (VALUE_WIDTH < PORT_VALUE_W) ? VALUE_WIDTH : PORT_VALUE_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          err_q, err_d;
  logic [SW-1:0] value_q;
  logic [SW-1:0] cur_val_q;
  logic          out_valid_q;
  logic [PORT_VALUE_W-1:0] out_value_q;
  logic          out_has_q;
  logic [CW-1:0] out_count_q;
  logic          out_err_q;

  logic          has;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [SW-1:0] rd_data;
  logic [CW-1:0] idx_p1;
  logic [PORT_VALUE_W-1:0] cur_ext;

  assign has    = cursor_q < count_q;
  assign idx_p1 = idx_q + ONE;

  assign status_o.has             = has;
  assign status_o.full            = count_q == FULL_COUNT;
  assign status_o.idx_eq_cursor   = idx_q == cursor_q;
  assign status_o.idx_p1_lt_count = idx_p1 < count_q;
  assign status_o.out_free        = !out_valid_q || !out_stall_i;

  // control registers
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    idx_d    = idx_q;
    err_d    = err_q;
    if (cmd_i.accept) begin
      err_d = 1'b0;
    end
    if (cmd_i.set_err) begin
      err_d = 1'b1;
    end
    case (cmd_i.cur_op)
      CUR_ZERO:  cursor_d = '0;
      CUR_INC:   cursor_d = cursor_q + ONE;
      CUR_COUNT: cursor_d = count_q;
      default:   cursor_d = cursor_q;
    endcase
    case (cmd_i.idx_op)
      IDX_COUNT:  idx_d = count_q;
      IDX_CURSOR: idx_d = cursor_q;
      IDX_DEC:    idx_d = idx_q - ONE;
      IDX_INC:    idx_d = idx_p1;
      default:    idx_d = idx_q;
    endcase
    if (cmd_i.count_inc) begin
      count_d = count_q + ONE;
    end else if (cmd_i.count_dec) begin
      count_d = count_q - ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      idx_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      idx_q    <= idx_d;
      err_q    <= err_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      value_q <= entry_value_i[SW-1:0];
    end
    if (cmd_i.load_value) begin
      cur_val_q <= value_q;
    end else if (cmd_i.load_cur) begin
      cur_val_q <= rd_data;
    end
    if (cmd_i.load_out) begin
      out_value_q <= has ? cur_ext : '0;
      out_has_q   <= has;
      out_count_q <= count_q;
      out_err_q   <= err_q;
    end
  end

  always_comb begin
    cur_ext         = '0;
    cur_ext[SW-1:0] = cur_val_q;
  end

  // ram port selection
  always_comb begin
    rd_en   = cmd_i.rd_sel != RD_NONE;
    case (cmd_i.rd_sel)
      RD_IDX_M1: rd_addr = AW'(idx_q - ONE);
      RD_IDX_P1: rd_addr = AW'(idx_p1);
      RD_CURSOR: rd_addr = cursor_q[AW-1:0];
      default:   rd_addr = idx_q[AW-1:0];
    endcase
    wr_en = cmd_i.wr_sel != WR_NONE;
    if (cmd_i.wr_sel == WR_VALUE) begin
      wr_addr = cursor_q[AW-1:0];
      wr_data = value_q;
    end else begin
      wr_addr = idx_q[AW-1:0];
      wr_data = rd_data;
    end
  end

  css_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign current_value_o = out_value_q;
  assign has_current_o   = out_has_q;
  assign entry_count_o   = out_count_q;
  assign full_error_o    = out_err_q;

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor beyond count");
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("count beyond depth");
  a_err_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_count_q == FULL_COUNT)
    else $error("full error reported with room left");
  a_no_value_without_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_has_q |-> out_value_q == '0)
    else $error("value reported with no current entry");
`endif

endmodule

### dv/css_sequence_checker.sv
`timescale 1ns / 100ps
// css_sequence_checker: watches both channels of cursor_sequence_store, predicts the
// status of every request taken and compares each result field by field
// depends on css_pkg for the request codes and port widths
module css_sequence_checker #(
  parameter int unsigned DEPTH       = css_pkg::DEPTH_DEFAULT,
  parameter int unsigned VALUE_WIDTH = css_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [css_pkg::KIND_W-1:0]       kind_i,
  input  logic [css_pkg::PORT_VALUE_W-1:0] entry_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [css_pkg::PORT_VALUE_W-1:0] current_value_i,
  input  logic                             has_current_i,
  input  logic [$clog2(DEPTH+1)-1:0]       entry_count_i,
  input  logic                             full_error_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      results_o,
  output int unsigned                      refusals_o,
  output int unsigned                      peak_count_o
);
  import css_pkg::*;

  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned REPORT_LIMIT = 100;
  localparam logic [PORT_VALUE_W-1:0] VALUE_MASK =
    PORT_VALUE_W'((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct packed {
    logic [PORT_VALUE_W-1:0] current_value;
    logic                    has_current;
    logic [CNT_W-1:0]        entry_count;
    logic                    full_error;
  } seq_status_t;

  logic [PORT_VALUE_W-1:0] seq_entries [DEPTH];
  int unsigned             seq_count;
  int unsigned             seq_cursor;
  seq_status_t             predicted_status_q [$];

  // applies one request to the predicted list and returns the status it reports
  function automatic seq_status_t apply_command(input logic [KIND_W-1:0] kind,
                                                input logic [PORT_VALUE_W-1:0] value);
    seq_status_t status;
    int unsigned k;
    status = '0;
    case (kind) inside
      // on an empty store the count is zero, so the cursor lands on "none" as well
      KIND_START: seq_cursor = 0;
      KIND_ADVANCE: if (seq_cursor < seq_count) seq_cursor++;
      KIND_INSERT, KIND_ATTACH: begin
        if (seq_count >= DEPTH) begin
          status.full_error = 1'b1;
        end else begin
          if (kind == KIND_INSERT) begin
            if (seq_cursor >= seq_count) seq_cursor = 0;
          end else if (seq_cursor < seq_count) begin
            seq_cursor++;
          end else begin
            seq_cursor = seq_count;
          end
          for (k = seq_count; k > seq_cursor; k--) seq_entries[k] = seq_entries[k-1];
          seq_entries[seq_cursor] = value & VALUE_MASK;
          seq_count++;
        end
      end
      KIND_REMOVE: begin
        if (seq_cursor < seq_count) begin
          for (k = seq_cursor; k + 1 < seq_count; k++) seq_entries[k] = seq_entries[k+1];
          seq_count--;
        end
      end
      default: ;
    endcase
    if (seq_cursor < seq_count) begin
      status.current_value = seq_entries[seq_cursor];
      status.has_current   = 1'b1;
    end
    status.entry_count = CNT_W'(seq_count);
    return status;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count_o++;
    // output bounded so a broken block cannot flood the log
    if (mismatch_count_o <= REPORT_LIMIT)
      $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
               $time, results_o, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seq_status_t seen;
    seq_status_t want;
    if (!rst_ni) begin
      seq_count        = 0;
      seq_cursor       = 0;
      predicted_status_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      results_o        = 0;
      refusals_o       = 0;
      peak_count_o     = 0;
    end else begin
      // results first: one leaving now cannot belong to a request taken at this edge
      if (out_valid_i && !out_stall_i) begin
        seen = {current_value_i, has_current_i, entry_count_i, full_error_i};
        results_o++;
        if (predicted_status_q.size() == 0) begin
          report_mismatch("result with no request outstanding", 64'(seen), '0);
        end else begin
          want = predicted_status_q.pop_front();
          if (seen.current_value !== want.current_value)
            report_mismatch("current_value", 64'(seen.current_value),
                            64'(want.current_value));
          if (seen.has_current !== want.has_current)
            report_mismatch("has_current", 64'(seen.has_current), 64'(want.has_current));
          if (seen.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(seen.entry_count), 64'(want.entry_count));
          if (seen.full_error !== want.full_error)
            report_mismatch("full_error", 64'(seen.full_error), 64'(want.full_error));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_command(kind_i, entry_value_i);
        if (want.full_error) refusals_o++;
        if (seq_count > peak_count_o) peak_count_o = seq_count;
        predicted_status_q.push_back(want);
      end
      pending_o = predicted_status_q.size();
    end
  end

endmodule

### dv/tb_cursor_sequence_store.sv
`timescale 1ns / 100ps
// tb_cursor_sequence_store: directed and random requests into the cursor sequence
// store under several idling patterns, with the verdict given at the end
// depends on css_pkg, cursor_sequence_store and css_sequence_checker
module tb_cursor_sequence_store;
  import css_pkg::*;

  localparam int unsigned DEPTH           = DEPTH_DEFAULT;
  localparam int unsigned VALUE_WIDTH     = VALUE_WIDTH_DEFAULT;
  localparam int unsigned CNT_W           = $clog2(DEPTH + 1);
  localparam int unsigned RANDOM_REQUESTS = 1200;
  localparam int unsigned CHUNK           = 60;
  localparam int unsigned UNUSED_PCT      = 5;
  // long output hold-off, well beyond the slowest request
  localparam int unsigned HOLD_CYCLES     = 300;
  // no handshake at all for this long means the block has hung
  localparam int unsigned QUIET_LIMIT     = 5000;
  // slowest request is a remove at the front of a full store, moving every later entry
  localparam int unsigned TAIL_CYCLES     = 3 * DEPTH + 40;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(int'(KIND_REMOVE) + 1);
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [KIND_W-1:0]       kind_i;
  logic [PORT_VALUE_W-1:0] entry_value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [PORT_VALUE_W-1:0] current_value_o;
  logic                    has_current_o;
  logic [CNT_W-1:0]        entry_count_o;
  logic                    full_error_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned refusals;
  int unsigned peak_count;

  // idling knobs, set by the request process and read by the result side
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_asked    = 0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles  = 0;

  cursor_sequence_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .entry_value_i   (entry_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_value_o (current_value_o),
    .has_current_o   (has_current_o),
    .entry_count_o   (entry_count_o),
    .full_error_o    (full_error_o)
  );

  css_sequence_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .kind_i           (kind_i),
    .entry_value_i    (entry_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .current_value_i  (current_value_o),
    .has_current_i    (has_current_o),
    .entry_count_i    (entry_count_o),
    .full_error_i     (full_error_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .results_o        (results),
    .refusals_o       (refusals),
    .peak_count_o     (peak_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side: random stalls at the current rate, or a long hold-off when asked
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: any cycle with a handshake on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offers one request, entered and left at a falling edge; the request is held
  // unchanged until the block takes it
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [PORT_VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    entry_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // stops offering until every outstanding request has been answered
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [KIND_W-1:0]       kind;
    logic [PORT_VALUE_W-1:0] value;
    int unsigned             chunk;
    int unsigned             pick;
    int unsigned             w_ins;
    int unsigned             w_att;
    int unsigned             w_rem;
    int unsigned             w_adv;
    int unsigned             directed;
    in_valid_i    = 1'b0;
    kind_i        = KIND_START;
    entry_value_i = '0;
    rst_ni        = 1'b0;
    w_ins = 0;
    w_att = 0;
    w_rem = 0;
    w_adv = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: every request on an empty store, unused codes included
    send_request(KIND_START, '0);
    send_request(KIND_ADVANCE, '1);
    send_request(KIND_REMOVE, '0);
    send_request(KIND_UNUSED_LO, '1);
    send_request(KIND_W'(int'(KIND_UNUSED_LO) + 1), '0);
    send_request(KIND_UNUSED_HI, 32'h5555_5555);
    // insert with nothing current goes to the front, attach after it
    send_request(KIND_INSERT, 32'hFFFF_FFFF);
    send_request(KIND_ATTACH, 32'h0000_0000);
    // step off the end, then attach with nothing current lands at the end
    send_request(KIND_ADVANCE, '0);
    send_request(KIND_ATTACH, 32'h8000_0000);
    send_request(KIND_START, '0);
    send_request(KIND_INSERT, 32'h0000_0001);
    send_request(KIND_REMOVE, '0);
    send_request(KIND_UNUSED_HI, '0);
    send_request(KIND_ADVANCE, '0);
    send_request(KIND_ADVANCE, '0);
    // remove of the last entry leaves no current entry
    send_request(KIND_REMOVE, '0);
    send_request(KIND_ADVANCE, '0);
    send_request(KIND_REMOVE, '0);
    send_request(KIND_INSERT, 32'hAAAA_AAAA);
    send_request(KIND_START, '0);
    send_request(KIND_REMOVE, '0);
    send_request(KIND_ADVANCE, 32'h7FFF_FFFF);
    directed = requests_sent;

    // random part: chunks that grow, shrink or churn the list, under each
    // idling pattern in turn; growth chunks run well into the full store
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % CHUNK == 0) begin
        chunk = n / CHUNK;
        case (chunk % 3)
          0: begin
            w_ins = 40; w_att = 40; w_rem = 5;  w_adv = 5;
          end
          1: begin
            w_ins = 8;  w_att = 7;  w_rem = 45; w_adv = 15;
          end
          default: begin
            w_ins = 20; w_att = 20; w_rem = 25; w_adv = 20;
          end
        endcase
        case ((chunk / 3) % 4)
          0: begin
            send_idle_pct = 0;  stall_pct = 0;
          end
          1: begin
            send_idle_pct = 78; stall_pct = 0;
          end
          2: begin
            send_idle_pct = 0;  stall_pct = 78;
          end
          default: begin
            send_idle_pct = 30; stall_pct = 30;
          end
        endcase
        // long output hold-off while requests keep coming, so the block backs up
        if (chunk == 1 || chunk == 13) hold_asked++;
        // full pause until every result is home
        if (chunk == 7 || chunk == 16) drain_results();
      end

      pick = $urandom_range(99);
      if (pick < UNUSED_PCT)
        kind = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      else if (pick < UNUSED_PCT + w_ins)
        kind = KIND_INSERT;
      else if (pick < UNUSED_PCT + w_ins + w_att)
        kind = KIND_ATTACH;
      else if (pick < UNUSED_PCT + w_ins + w_att + w_rem)
        kind = KIND_REMOVE;
      else if (pick < UNUSED_PCT + w_ins + w_att + w_rem + w_adv)
        kind = KIND_ADVANCE;
      else
        kind = KIND_START;

      // mostly random values, with the extremes now and then
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       value = '0;
          1:       value = '1;
          2:       value = 32'h8000_0000;
          default: value = 32'h0000_0001;
        endcase
      end else begin
        value = $urandom;
      end
      send_request(kind, value);
    end

    // wind down: wait for the last results, then a quiet tail for strays
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d requests (%0d directed), %0d results, %0d refused when full",
             requests_sent, directed, results, refusals);
    $display("peak count %0d; idling none, sender 78%%, receiver 78%%, both 30%%",
             peak_count);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
